// ----- design/szoa_pkg.sv -----
// Shared types and codes for the sensor zero-offset averager.
// No dependencies; used by the top level.
`timescale 1ns / 1ps

package szoa_pkg;

  // Sequencer states of the top level
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV,
    ST_FIN
  } szoa_state_e;

  // Configuration register indexes
  localparam logic [1:0] REG_ZERO_AVG   = 2'd0;
  localparam logic [1:0] REG_SENSOR_AVG = 2'd1;

  // Result kinds, also the input mode codes
  localparam logic KIND_ZERO  = 1'b0;
  localparam logic KIND_PRESS = 1'b1;

  // Reset values of the count registers
  localparam int unsigned ZERO_AVG_RST   = 4;
  localparam int unsigned SENSOR_AVG_RST = 2;

endpackage

// ----- design/szoa_div.sv -----
// Bit-serial restoring divider: unsigned dividend by unsigned divisor,
// one quotient bit per cycle. Depends on nothing outside this file.
`timescale 1ns / 1ps

module szoa_div #(
  parameter int unsigned DVD_W = 16,
  parameter int unsigned DVS_W = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned STEP_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W-1:0] rem_q, rem_d;

  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             ge;

  // One restoring step: shift in the next dividend bit, trial subtract
  assign rem_sh  = {rem_q, dvd_q[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign ge      = (rem_sh >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      if (DVD_W > 1) begin
        dvd_d = {dvd_q[DVD_W-2:0], ge};
      end else begin
        dvd_d = DVD_W'(ge);
      end
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Shift registers of the datapath
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

// ----- design/sensor_zero_offset_averager.sv -----
// Sensor zero-offset averager: per-channel block averages of ADC samples.
// An item that closes a block passes the capture registers, the accumulate
// step, the serial divide (one bit a cycle) and the output register.
// A new item is taken only in the idle state, once the last one is through;
// a held result that blocks the output register holds off the next item.
// Reset clears channel state, loads counts 4 and 2; uses szoa_pkg, szoa_div.
`timescale 1ns / 1ps

module sensor_zero_offset_averager
  import szoa_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 3,
  parameter int unsigned ADC_BITS     = 10,
  parameter int unsigned MAX_AVG      = 32,
  localparam int unsigned CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
  localparam int unsigned CNT_W = $clog2(MAX_AVG + 1),
  localparam int unsigned AVG_W = ADC_BITS + 1,
  localparam int unsigned PRS_W = ADC_BITS + 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // input items
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    func_i,
  input  logic [CH_W-1:0]         channel_i,
  input  logic [ADC_BITS-1:0]     sample_i,
  // result items
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [CH_W-1:0]         out_channel_o,
  output logic                    out_kind_o,
  output logic signed [AVG_W-1:0] avg_counts_o,
  output logic signed [PRS_W-1:0] pressure_o,
  // configuration writes
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [1:0]              cfg_index_i,
  input  logic [CNT_W-1:0]        cfg_wdata_i
);

  localparam int unsigned SUM_W = ADC_BITS + CNT_W + 1;
  localparam int unsigned ZRST  = (ZERO_AVG_RST > MAX_AVG) ? MAX_AVG : ZERO_AVG_RST;
  localparam int unsigned SRST  = (SENSOR_AVG_RST > MAX_AVG) ? MAX_AVG : SENSOR_AVG_RST;

  szoa_state_e state_q, state_d;

  // captured item
  logic                func_q;
  logic [CH_W-1:0]     ch_q;
  logic [ADC_BITS-1:0] smp_q;

  // per-channel state
  logic [SUM_W-1:0]    sum_q  [NUM_CHANNELS];
  logic [CNT_W-1:0]    cnt_q  [NUM_CHANNELS];
  logic                mode_q [NUM_CHANNELS];
  logic [ADC_BITS-1:0] zoff_q [NUM_CHANNELS];

  // count registers
  logic [CNT_W-1:0]    zcnt_q, scnt_q;

  // sign of the finished block
  logic                neg_q;

  // output register
  logic                    out_valid_q;
  logic [CH_W-1:0]         out_ch_q;
  logic                    out_kind_q;
  logic [AVG_W-1:0]        out_avg_q;
  logic [PRS_W-1:0]        out_prs_q;

  logic in_acc, ch_ok, div_start, out_load, acc_en;
  logic div_done;
  logic [SUM_W-2:0] div_q;

  // ---------------------------------------------------------------
  // Accumulate step for the captured item
  logic             mode_chg;
  logic [SUM_W-1:0] base_sum, add_val, new_sum, neg_sum;
  logic [CNT_W-1:0] base_cnt, new_cnt, target;
  logic             blk_done;

  always_comb begin
    mode_chg = (mode_q[ch_q] != func_q);
    base_sum = mode_chg ? '0 : sum_q[ch_q];
    base_cnt = mode_chg ? '0 : cnt_q[ch_q];
    if (func_q == KIND_PRESS) begin
      add_val = SUM_W'(smp_q) - SUM_W'(zoff_q[ch_q]);
    end else begin
      add_val = SUM_W'(smp_q);
    end
    new_sum  = base_sum + add_val;
    new_cnt  = base_cnt + 1'b1;
    neg_sum  = ~new_sum + 1'b1;
    target   = (func_q == KIND_PRESS) ? scnt_q : zcnt_q;
    blk_done = (new_cnt >= target);
  end

  // Serial divide of the block magnitude by the sample count
  szoa_div #(
    .DVD_W (SUM_W - 1),
    .DVS_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (new_sum[SUM_W-1] ? neg_sum[SUM_W-2:0] : new_sum[SUM_W-2:0]),
    .divisor_i  (new_cnt),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // ---------------------------------------------------------------
  // Sequencer
  assign in_acc = in_valid_i && in_ready_o;
  assign ch_ok  = ({1'b0, channel_i} < (CH_W + 1)'(NUM_CHANNELS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    acc_en     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && ch_ok) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        acc_en = 1'b1;
        if (blk_done) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Capture of an accepted item, and of the block sign at divide start
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= func_i;
      ch_q   <= channel_i;
      smp_q  <= sample_i;
    end
    if (div_start) begin
      neg_q <= new_sum[SUM_W-1];
    end
  end

  // ---------------------------------------------------------------
  // Signed average and pressure = avg * 5 (zero for zero-offset items)
  logic [AVG_W-1:0] avg_mag, avg_val;
  logic [PRS_W-1:0] avg_ext, prs_val;

  always_comb begin
    avg_mag = div_q[AVG_W-1:0];
    avg_val = neg_q ? (~avg_mag + 1'b1) : avg_mag;
    avg_ext = {{(PRS_W - AVG_W){avg_val[AVG_W-1]}}, avg_val};
    prs_val = (func_q == KIND_PRESS) ? ((avg_ext << 2) + avg_ext) : '0;
  end

  // Per-channel state and count registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        sum_q[i]  <= '0;
        cnt_q[i]  <= '0;
        mode_q[i] <= 1'b0;
        zoff_q[i] <= '0;
      end
      zcnt_q <= CNT_W'(ZRST);
      scnt_q <= CNT_W'(SRST);
    end else begin
      if (acc_en) begin
        mode_q[ch_q] <= func_q;
        sum_q[ch_q]  <= blk_done ? '0 : new_sum;
        cnt_q[ch_q]  <= blk_done ? '0 : new_cnt;
      end
      if (out_load && (func_q == KIND_ZERO)) begin
        zoff_q[ch_q] <= avg_val[ADC_BITS-1:0];
      end
      // count writes outside 1..MAX_AVG are dropped
      if (cfg_valid_i && (cfg_wdata_i != '0) &&
          ((CNT_W + 1)'(cfg_wdata_i) <= (CNT_W + 1)'(MAX_AVG))) begin
        case (cfg_index_i)
          REG_ZERO_AVG:   zcnt_q <= cfg_wdata_i;
          REG_SENSOR_AVG: scnt_q <= cfg_wdata_i;
          default:        ;
        endcase
      end
    end
  end

  assign cfg_ready_o = 1'b1;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ch_q   <= ch_q;
      out_kind_q <= func_q;
      out_avg_q  <= avg_val;
      out_prs_q  <= prs_val;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_ch_q;
  assign out_kind_o    = out_kind_q;
  assign avg_counts_o  = out_avg_q;
  assign pressure_o    = out_prs_q;

`ifndef SYNTH
  // zero-offset results carry no pressure
  a_zero_press : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_kind_o == KIND_ZERO) |-> pressure_o == '0)
    else $error("zero-offset result with nonzero pressure");

  // pressure result is five times the average
  a_press_scale : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_kind_o == KIND_PRESS) |->
      pressure_o == PRS_W'((avg_counts_o <<< 2) + PRS_W'(avg_counts_o)))
    else $error("pressure is not avg_counts times five");

  // divider finishes only while the sequencer waits for it
  a_div_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider done outside divide state");

  // a block never grows past the largest count
  a_cnt_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ACC |-> (CNT_W + 1)'(new_cnt) <= (CNT_W + 1)'(MAX_AVG))
    else $error("sample count beyond maximum block size");
`endif

endmodule
